FILE: rtl/core/ecsm_pkg.sv
package ecsm_pkg;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_COEFF_A = 1'b1;

    localparam logic [63:0] MODULUS_RESET = 64'd1157920892373161953;
    localparam logic [63:0] COEFF_A_RESET = 64'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_X,
        ST_RED_Y,
        ST_LOOP,
        ST_PADD,
        ST_NEG,
        ST_CHK,
        ST_DBL_SQ,
        ST_DBL_2X,
        ST_DBL_3X,
        ST_DBL_A,
        ST_DBL_DEN,
        ST_CH_NUM,
        ST_CH_DEN,
        ST_INV_INIT,
        ST_INV_TEST,
        ST_INV_DIV,
        ST_INV_MUL,
        ST_INV_SUB,
        ST_LAM,
        ST_X_SQ,
        ST_X_SUM,
        ST_X_DIFF,
        ST_Y_DIFF,
        ST_Y_MUL,
        ST_Y_SUB,
        ST_NEXT,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/core/ecsm_alu.sv
module ecsm_alu #(
    parameter int W = 61
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ecsm_pkg::alu_req_t req,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    input  logic [W-1:0]       m,
    output logic               done,
    output logic [W-1:0]       res,
    output logic [W-1:0]       quo
);
    import ecsm_pkg::*;

    localparam int CW = $clog2(W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    alu_op_t           op_reg, op_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      aux_reg, aux_next;
    logic [W-1:0]      bop_reg, bop_next;

    logic [W:0]        add_s;
    logic [W-1:0]      add_r;
    logic [W-1:0]      sub_r;
    logic [W:0]        dbl_s;
    logic [W-1:0]      dbl_r;
    logic [W:0]        mac_s;
    logic [W-1:0]      mac_r;
    logic [W:0]        div_t;
    logic              div_q;
    logic [W-1:0]      div_r;

    always_comb
    begin
        add_s = {1'b0, a} + {1'b0, b};
        add_r = (add_s >= {1'b0, m}) ? W'(add_s - {1'b0, m}) : add_s[W-1:0];
        sub_r = (a >= b) ? (a - b) : (a - b + m);

        dbl_s = {acc_reg, 1'b0};
        dbl_r = (dbl_s >= {1'b0, m}) ? W'(dbl_s - {1'b0, m}) : dbl_s[W-1:0];
        mac_s = {1'b0, dbl_r} + {1'b0, aux_reg};
        if (bop_reg[W-1])
        begin
            mac_r = (mac_s >= {1'b0, m}) ? W'(mac_s - {1'b0, m}) : mac_s[W-1:0];
        end
        else
        begin
            mac_r = dbl_r;
        end

        div_t = {acc_reg, aux_reg[W-1]};
        div_q = (div_t >= {1'b0, bop_reg});
        div_r = div_q ? W'(div_t - {1'b0, bop_reg}) : div_t[W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        aux_next  = aux_reg;
        bop_next  = bop_reg;
        if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                acc_next = mac_r;
                bop_next = {bop_reg[W-2:0], 1'b0};
            end
            else
            begin
                acc_next = div_r;
                aux_next = {aux_reg[W-2:0], div_q};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            op_next = req.op;
            unique case (req.op)
                ALU_ADD:
                begin
                    acc_next  = add_r;
                    done_next = 1'b1;
                end
                ALU_SUB:
                begin
                    acc_next  = sub_r;
                    done_next = 1'b1;
                end
                ALU_MUL, ALU_DIV:
                begin
                    acc_next  = '0;
                    aux_next  = a;
                    bop_next  = b;
                    cnt_next  = CW'(W - 1);
                    busy_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_ADD;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        aux_reg <= aux_next;
        bop_reg <= bop_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;
    assign quo  = aux_reg;

endmodule

FILE: rtl/core/ec_point_scalar_multiply.sv
// Sequence: three operand reductions, then per scalar bit up to two
// point ops on one shared modular ALU; each is 3 (add) or 4 (double) multiplies
// plus a modular inverse by extended Euclid steps (divide, multiply, subtract).
// Base at infinity or modulus below 3: no reductions; the result is at infinity.
// Throughput: one word at a time; the input stalls until the result is loaded.
// Reset: asynchronous active low; control and config registers reset, block idle.
module ec_point_scalar_multiply #(
    parameter int FIELD_BITS  = 61,
    parameter int SCALAR_BITS = 63
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [FIELD_BITS-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_BITS-1:0]  base_x,
    input  logic [FIELD_BITS-1:0]  base_y,
    input  logic                   base_at_infinity,
    input  logic [SCALAR_BITS-1:0] scalar,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FIELD_BITS-1:0]  result_x,
    output logic [FIELD_BITS-1:0]  result_y,
    output logic                   result_at_infinity
);
    import ecsm_pkg::*;

    localparam int W = FIELD_BITS;

    state_t state_reg, state_next;

    logic [W-1:0] mod_reg, mod_next;
    logic [W-1:0] coef_reg, coef_next;

    logic                   issued_reg, issued_next;
    logic                   dbl_reg, dbl_next;
    logic [SCALAR_BITS-1:0] k_reg, k_next;
    logic                   acc_inf_reg, acc_inf_next;
    logic                   q_inf_reg, q_inf_next;
    logic                   out_valid_reg, out_valid_next;

    logic [W-1:0] accx_reg, accx_next;
    logic [W-1:0] accy_reg, accy_next;
    logic [W-1:0] qx_reg, qx_next;
    logic [W-1:0] qy_reg, qy_next;
    logic [W-1:0] ca_reg, ca_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] lam_reg, lam_next;
    logic [W-1:0] uu_reg, uu_next;
    logic [W-1:0] rx_reg, rx_next;
    logic [W-1:0] r0_reg, r0_next;
    logic [W-1:0] r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next;
    logic [W-1:0] t1_reg, t1_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] resx_reg, resx_next;
    logic [W-1:0] resy_reg, resy_next;
    logic         resi_reg, resi_next;

    alu_req_t     alu_req;
    logic         alu_use;
    logic [W-1:0] alu_a;
    logic [W-1:0] alu_b;
    logic         alu_done;
    logic [W-1:0] alu_res;
    logic [W-1:0] alu_quo;

    logic [W-1:0] px;
    logic [W-1:0] py;

    ecsm_alu #(.W(W)) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (alu_a),
        .b     (alu_b),
        .m     (mod_reg),
        .done  (alu_done),
        .res   (alu_res),
        .quo   (alu_quo)
    );

    assign px = dbl_reg ? qx_reg : accx_reg;
    assign py = dbl_reg ? qy_reg : accy_reg;

    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        coef_next      = coef_reg;
        issued_next    = issued_reg;
        dbl_next       = dbl_reg;
        k_next         = k_reg;
        acc_inf_next   = acc_inf_reg;
        q_inf_next     = q_inf_reg;
        out_valid_next = out_valid_reg && out_stall;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        ca_next        = ca_reg;
        tmp_next       = tmp_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        lam_next       = lam_reg;
        uu_next        = uu_reg;
        rx_next        = rx_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        quo_next       = quo_reg;
        resx_next      = resx_reg;
        resy_next      = resy_reg;
        resi_next      = resi_reg;
        alu_use        = 1'b0;
        alu_req.op     = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS: mod_next  = cfg_data;
                CFG_COEFF_A: coef_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    qx_next      = base_x;
                    qy_next      = base_y;
                    k_next       = scalar;
                    acc_inf_next = 1'b1;
                    q_inf_next   = 1'b0;
                    if (base_at_infinity || (mod_reg < W'(3)))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_RED_A;
                    end
                end
            end
            ST_RED_A:
            begin
                alu_use = 1'b1; alu_req.op = ALU_DIV; alu_a = coef_reg; alu_b = mod_reg;
                if (alu_done)
                begin
                    ca_next    = alu_res;
                    state_next = ST_RED_X;
                end
            end
            ST_RED_X:
            begin
                alu_use = 1'b1; alu_req.op = ALU_DIV; alu_a = qx_reg; alu_b = mod_reg;
                if (alu_done)
                begin
                    qx_next    = alu_res;
                    state_next = ST_RED_Y;
                end
            end
            ST_RED_Y:
            begin
                alu_use = 1'b1; alu_req.op = ALU_DIV; alu_a = qy_reg; alu_b = mod_reg;
                if (alu_done)
                begin
                    qy_next    = alu_res;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    dbl_next   = !k_reg[0];
                    state_next = ST_PADD;
                end
            end
            ST_PADD:
            begin
                if (dbl_reg ? q_inf_reg : acc_inf_reg)
                begin
                    if (!dbl_reg)
                    begin
                        accx_next    = qx_reg;
                        accy_next    = qy_reg;
                        acc_inf_next = q_inf_reg;
                    end
                    state_next = ST_NEXT;
                end
                else if (q_inf_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = '0; alu_b = qy_reg;
                if (alu_done)
                begin
                    tmp_next   = alu_res;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                priority if (px == qx_reg && py == tmp_reg)
                begin
                    if (dbl_reg)
                    begin
                        qx_next    = '0;
                        qy_next    = '0;
                        q_inf_next = 1'b1;
                    end
                    else
                    begin
                        accx_next    = '0;
                        accy_next    = '0;
                        acc_inf_next = 1'b1;
                    end
                    state_next = ST_NEXT;
                end
                else if (px == qx_reg && py == qy_reg)
                begin
                    state_next = ST_DBL_SQ;
                end
                else
                begin
                    state_next = ST_CH_NUM;
                end
            end
            ST_DBL_SQ:
            begin
                alu_use = 1'b1; alu_req.op = ALU_MUL; alu_a = px; alu_b = px;
                if (alu_done)
                begin
                    tmp_next   = alu_res;
                    state_next = ST_DBL_2X;
                end
            end
            ST_DBL_2X:
            begin
                alu_use = 1'b1; alu_req.op = ALU_ADD; alu_a = tmp_reg; alu_b = tmp_reg;
                if (alu_done)
                begin
                    num_next   = alu_res;
                    state_next = ST_DBL_3X;
                end
            end
            ST_DBL_3X:
            begin
                alu_use = 1'b1; alu_req.op = ALU_ADD; alu_a = num_reg; alu_b = tmp_reg;
                if (alu_done)
                begin
                    num_next   = alu_res;
                    state_next = ST_DBL_A;
                end
            end
            ST_DBL_A:
            begin
                alu_use = 1'b1; alu_req.op = ALU_ADD; alu_a = num_reg; alu_b = ca_reg;
                if (alu_done)
                begin
                    num_next   = alu_res;
                    state_next = ST_DBL_DEN;
                end
            end
            ST_DBL_DEN:
            begin
                alu_use = 1'b1; alu_req.op = ALU_ADD; alu_a = py; alu_b = py;
                if (alu_done)
                begin
                    den_next   = alu_res;
                    state_next = ST_INV_INIT;
                end
            end
            ST_CH_NUM:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = qy_reg; alu_b = py;
                if (alu_done)
                begin
                    num_next   = alu_res;
                    state_next = ST_CH_DEN;
                end
            end
            ST_CH_DEN:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = qx_reg; alu_b = px;
                if (alu_done)
                begin
                    den_next   = alu_res;
                    state_next = ST_INV_INIT;
                end
            end
            ST_INV_INIT:
            begin
                r0_next    = mod_reg;
                r1_next    = den_reg;
                t0_next    = '0;
                t1_next    = W'(1);
                state_next = ST_INV_TEST;
            end
            ST_INV_TEST:
            begin
                if (r1_reg == '0)
                begin
                    den_next   = (r0_reg == W'(1)) ? t0_reg : '0;
                    state_next = ST_LAM;
                end
                else
                begin
                    state_next = ST_INV_DIV;
                end
            end
            ST_INV_DIV:
            begin
                alu_use = 1'b1; alu_req.op = ALU_DIV; alu_a = r0_reg; alu_b = r1_reg;
                if (alu_done)
                begin
                    quo_next   = (alu_quo == mod_reg) ? '0 : alu_quo;
                    tmp_next   = alu_res;
                    state_next = ST_INV_MUL;
                end
            end
            ST_INV_MUL:
            begin
                alu_use = 1'b1; alu_req.op = ALU_MUL; alu_a = quo_reg; alu_b = t1_reg;
                if (alu_done)
                begin
                    uu_next    = alu_res;
                    state_next = ST_INV_SUB;
                end
            end
            ST_INV_SUB:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = t0_reg; alu_b = uu_reg;
                if (alu_done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = tmp_reg;
                    t0_next    = t1_reg;
                    t1_next    = alu_res;
                    state_next = ST_INV_TEST;
                end
            end
            ST_LAM:
            begin
                alu_use = 1'b1; alu_req.op = ALU_MUL; alu_a = num_reg; alu_b = den_reg;
                if (alu_done)
                begin
                    lam_next   = alu_res;
                    state_next = ST_X_SQ;
                end
            end
            ST_X_SQ:
            begin
                alu_use = 1'b1; alu_req.op = ALU_MUL; alu_a = lam_reg; alu_b = lam_reg;
                if (alu_done)
                begin
                    tmp_next   = alu_res;
                    state_next = ST_X_SUM;
                end
            end
            ST_X_SUM:
            begin
                alu_use = 1'b1; alu_req.op = ALU_ADD; alu_a = px; alu_b = qx_reg;
                if (alu_done)
                begin
                    uu_next    = alu_res;
                    state_next = ST_X_DIFF;
                end
            end
            ST_X_DIFF:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = tmp_reg; alu_b = uu_reg;
                if (alu_done)
                begin
                    rx_next    = alu_res;
                    state_next = ST_Y_DIFF;
                end
            end
            ST_Y_DIFF:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = px; alu_b = rx_reg;
                if (alu_done)
                begin
                    uu_next    = alu_res;
                    state_next = ST_Y_MUL;
                end
            end
            ST_Y_MUL:
            begin
                alu_use = 1'b1; alu_req.op = ALU_MUL; alu_a = lam_reg; alu_b = uu_reg;
                if (alu_done)
                begin
                    tmp_next   = alu_res;
                    state_next = ST_Y_SUB;
                end
            end
            ST_Y_SUB:
            begin
                alu_use = 1'b1; alu_req.op = ALU_SUB; alu_a = tmp_reg; alu_b = py;
                if (alu_done)
                begin
                    if (dbl_reg)
                    begin
                        qx_next    = rx_reg;
                        qy_next    = alu_res;
                        q_inf_next = 1'b0;
                    end
                    else
                    begin
                        accx_next    = rx_reg;
                        accy_next    = alu_res;
                        acc_inf_next = 1'b0;
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!dbl_reg)
                begin
                    dbl_next   = 1'b1;
                    state_next = ST_PADD;
                end
                else
                begin
                    k_next     = k_reg >> 1;
                    state_next = ST_LOOP;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    resx_next      = acc_inf_reg ? '0 : accx_reg;
                    resy_next      = acc_inf_reg ? '0 : accy_reg;
                    resi_next      = acc_inf_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        alu_req.start = alu_use && !issued_reg;
        if (alu_done)
        begin
            issued_next = 1'b0;
        end
        else if (alu_req.start)
        begin
            issued_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= W'(MODULUS_RESET);
            coef_reg      <= W'(COEFF_A_RESET);
            issued_reg    <= 1'b0;
            dbl_reg       <= 1'b0;
            k_reg         <= '0;
            acc_inf_reg   <= 1'b1;
            q_inf_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            coef_reg      <= coef_next;
            issued_reg    <= issued_next;
            dbl_reg       <= dbl_next;
            k_reg         <= k_next;
            acc_inf_reg   <= acc_inf_next;
            q_inf_reg     <= q_inf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        ca_reg   <= ca_next;
        tmp_reg  <= tmp_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        lam_reg  <= lam_next;
        uu_reg   <= uu_next;
        rx_reg   <= rx_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        quo_reg  <= quo_next;
        resx_reg <= resx_next;
        resy_reg <= resy_next;
        resi_reg <= resi_next;
    end

    assign in_stall           = (state_reg != ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign result_x           = resx_reg;
    assign result_y           = resy_reg;
    assign result_at_infinity = resi_reg;

endmodule
